// File: design/vcqf_pkg.sv
// shared types, constants and threshold tables of the variant call quality filter
package vcqf_pkg;

    localparam int CountW      = 16;
    localparam int ScoreW      = 32;
    localparam int CovW        = 32;
    localparam int LenW        = 8;
    localparam int BaseW       = 4;
    localparam int NumBases    = 12;
    localparam int BasesW      = BaseW * NumBases;
    localparam int PctW        = 23;
    localparam int ThrW        = 6;
    localparam int DivW        = 32;
    localparam int DivStepBits = 2;

    localparam int PctFull     = 100;
    localparam int HomoPct     = 25;
    localparam int SubMin      = 3;
    localparam int SubMax      = 20;
    localparam int IndelMin    = 2;
    localparam int IndelMax    = 11;

    localparam int SubIdxW     = 5;
    localparam int IndelIdxW   = 4;

    localparam int RegIdxW     = 1;
    localparam logic [RegIdxW-1:0] RegBypass  = 1'b0;
    localparam logic [RegIdxW-1:0] RegReadLen = 1'b1;

    typedef struct packed {
        logic bypass;
        logic read_set;
    } cfg_t;

    typedef struct packed {
        logic [ThrW-1:0] pct;
        logic [ThrW-1:0] scr;
    } thr_t;

    typedef struct packed {
        logic            homo_del;
        logic            bypass;
        logic            cnt_ok;
        logic            cov_zero;
        logic [ThrW-1:0] thr_pct;
        logic [ThrW-1:0] thr_scr;
    } side_t;

    localparam int SideW = $bits(side_t);

    function automatic thr_t mk_thr(input int pct, input int scr);
        thr_t t;
        t.pct = ThrW'(pct);
        t.scr = ThrW'(scr);
        return t;
    endfunction

    // rows for counts 3 to 20
    function automatic thr_t sub_thr(input logic set, input logic [SubIdxW-1:0] idx);
        thr_t t;
        unique case ({set, idx})
            {1'b0, 5'd0}:  t = mk_thr(15, 16);
            {1'b0, 5'd1}:  t = mk_thr(17, 17);
            {1'b0, 5'd2}:  t = mk_thr(18, 18);
            {1'b0, 5'd3}:  t = mk_thr(20, 18);
            {1'b0, 5'd4}:  t = mk_thr(21, 20);
            {1'b0, 5'd5}:  t = mk_thr(22, 21);
            {1'b0, 5'd6}:  t = mk_thr(22, 21);
            {1'b0, 5'd7}:  t = mk_thr(24, 21);
            {1'b0, 5'd8}:  t = mk_thr(24, 21);
            {1'b0, 5'd9}:  t = mk_thr(28, 21);
            {1'b0, 5'd10}: t = mk_thr(29, 22);
            {1'b0, 5'd11}: t = mk_thr(29, 23);
            {1'b0, 5'd12}: t = mk_thr(32, 24);
            {1'b0, 5'd13}: t = mk_thr(32, 25);
            {1'b0, 5'd14}: t = mk_thr(35, 25);
            {1'b0, 5'd15}: t = mk_thr(35, 25);
            {1'b0, 5'd16}: t = mk_thr(35, 25);
            {1'b0, 5'd17}: t = mk_thr(40, 25);
            {1'b1, 5'd0}:  t = mk_thr(15, 16);
            {1'b1, 5'd1}:  t = mk_thr(17, 20);
            {1'b1, 5'd2}:  t = mk_thr(18, 20);
            {1'b1, 5'd3}:  t = mk_thr(20, 21);
            {1'b1, 5'd4}:  t = mk_thr(21, 21);
            {1'b1, 5'd5}:  t = mk_thr(22, 21);
            {1'b1, 5'd6}:  t = mk_thr(24, 22);
            {1'b1, 5'd7}:  t = mk_thr(25, 23);
            {1'b1, 5'd8}:  t = mk_thr(27, 23);
            {1'b1, 5'd9}:  t = mk_thr(27, 25);
            {1'b1, 5'd10}: t = mk_thr(29, 25);
            {1'b1, 5'd11}: t = mk_thr(30, 27);
            {1'b1, 5'd12}: t = mk_thr(31, 27);
            {1'b1, 5'd13}: t = mk_thr(34, 27);
            {1'b1, 5'd14}: t = mk_thr(34, 27);
            {1'b1, 5'd15}: t = mk_thr(34, 29);
            {1'b1, 5'd16}: t = mk_thr(35, 29);
            {1'b1, 5'd17}: t = mk_thr(40, 29);
            default:       t = mk_thr(0, 0);
        endcase
        return t;
    endfunction

    // rows for counts 2 to 11
    function automatic thr_t indel_thr(input logic set, input logic [IndelIdxW-1:0] idx);
        thr_t t;
        unique case ({set, idx})
            {1'b0, 4'd0}: t = mk_thr(10, 16);
            {1'b0, 4'd1}: t = mk_thr(12, 21);
            {1'b0, 4'd2}: t = mk_thr(13, 21);
            {1'b0, 4'd3}: t = mk_thr(14, 22);
            {1'b0, 4'd4}: t = mk_thr(14, 22);
            {1'b0, 4'd5}: t = mk_thr(1, 23);
            {1'b0, 4'd6}: t = mk_thr(1, 25);
            {1'b0, 4'd7}: t = mk_thr(1, 25);
            {1'b0, 4'd8}: t = mk_thr(1, 30);
            {1'b0, 4'd9}: t = mk_thr(1, 40);
            {1'b1, 4'd0}: t = mk_thr(9, 21);
            {1'b1, 4'd1}: t = mk_thr(12, 22);
            {1'b1, 4'd2}: t = mk_thr(12, 22);
            {1'b1, 4'd3}: t = mk_thr(13, 24);
            {1'b1, 4'd4}: t = mk_thr(15, 25);
            {1'b1, 4'd5}: t = mk_thr(17, 25);
            {1'b1, 4'd6}: t = mk_thr(18, 25);
            {1'b1, 4'd7}: t = mk_thr(2, 26);
            {1'b1, 4'd8}: t = mk_thr(1, 27);
            {1'b1, 4'd9}: t = mk_thr(1, 40);
            default:      t = mk_thr(0, 0);
        endcase
        return t;
    endfunction

endpackage

// File: design/vcqf_div_pipe.sv
// pipelined restoring divider, a few quotient bits per register stage, with sideband
module vcqf_div_pipe #(
    parameter int W        = vcqf_pkg::DivW,
    parameter int DW       = 16,
    parameter int StepBits = vcqf_pkg::DivStepBits,
    parameter int SideW    = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     in_dividend,
    input  logic [DW-1:0]    in_divisor,
    input  logic [SideW-1:0] in_side,
    output logic             out_valid,
    output logic [W-1:0]     out_quotient,
    output logic [SideW-1:0] out_side
);

    localparam int Stages = W / StepBits;

    logic             vld_reg  [Stages];
    logic [DW-1:0]    rem_reg  [Stages];
    logic [W-1:0]     quo_reg  [Stages];
    logic [DW-1:0]    dsr_reg  [Stages];
    logic [SideW-1:0] side_reg [Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic             vld_in;
        logic [DW-1:0]    rem_in;
        logic [W-1:0]     quo_in;
        logic [DW-1:0]    dsr_in;
        logic [SideW-1:0] side_in;
        logic [DW-1:0]    rem_next;
        logic [W-1:0]     quo_next;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign quo_in  = in_dividend;
            assign dsr_in  = in_divisor;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign dsr_in  = dsr_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb begin
            logic [DW:0] trial;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int k = 0; k < StepBits; k++) begin
                trial = {rem_next, quo_next[W-1]};
                if (trial >= {1'b0, dsr_in}) begin
                    rem_next = DW'(trial - {1'b0, dsr_in});
                    quo_next = {quo_next[W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DW-1:0];
                    quo_next = {quo_next[W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                dsr_reg[s]  <= dsr_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid    = vld_reg[Stages-1];
    assign out_quotient = quo_reg[Stages-1];
    assign out_side     = side_reg[Stages-1];

endmodule

// File: design/vcqf_front.sv
// input stage: variant class, homopolymer check, count clamp, table lookup, count times 100
module vcqf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  vcqf_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic [vcqf_pkg::CountW-1:0]   in_count,
    input  logic [vcqf_pkg::ScoreW-1:0]   in_score,
    input  logic [vcqf_pkg::CovW-1:0]     in_cov,
    input  logic [vcqf_pkg::LenW-1:0]     in_ref_len,
    input  logic [vcqf_pkg::LenW-1:0]     in_alt_len,
    input  logic [vcqf_pkg::BasesW-1:0]   in_bases,
    output logic                          out_valid,
    output logic [vcqf_pkg::CountW-1:0]   out_count,
    output logic [vcqf_pkg::ScoreW-1:0]   out_score,
    output logic [vcqf_pkg::CovW-1:0]     out_cov,
    output logic [vcqf_pkg::PctW-1:0]     out_pct_num,
    output vcqf_pkg::side_t               out_side
);

    logic                        vld_reg;
    logic [vcqf_pkg::CountW-1:0] cnt_reg;
    logic [vcqf_pkg::ScoreW-1:0] sum_reg;
    logic [vcqf_pkg::CovW-1:0]   cov_reg;
    logic [vcqf_pkg::PctW-1:0]   num_reg;
    vcqf_pkg::side_t             side_reg;

    logic                           is_sub;
    logic                           is_del;
    logic                           run_one;
    logic                           sub_ok;
    logic                           indel_ok;
    logic [vcqf_pkg::SubIdxW-1:0]   sub_idx;
    logic [vcqf_pkg::IndelIdxW-1:0] indel_idx;
    vcqf_pkg::thr_t                 sub_row;
    vcqf_pkg::thr_t                 indel_row;
    vcqf_pkg::thr_t                 row;
    vcqf_pkg::side_t                side_next;
    logic [vcqf_pkg::PctW-1:0]      num_next;

    assign is_sub = (in_ref_len == in_alt_len);
    assign is_del = (in_ref_len > in_alt_len);

    // all twelve base codes equal to the oldest
    always_comb begin
        run_one = 1'b1;
        for (int i = 1; i < vcqf_pkg::NumBases; i++) begin
            if (in_bases[i*vcqf_pkg::BaseW +: vcqf_pkg::BaseW]
                != in_bases[vcqf_pkg::BaseW-1:0]) begin
                run_one = 1'b0;
            end
        end
    end

    assign sub_ok   = (in_count >= vcqf_pkg::CountW'(vcqf_pkg::SubMin));
    assign indel_ok = (in_count >= vcqf_pkg::CountW'(vcqf_pkg::IndelMin));

    always_comb begin
        if (in_count > vcqf_pkg::CountW'(vcqf_pkg::SubMax)) begin
            sub_idx = vcqf_pkg::SubIdxW'(vcqf_pkg::SubMax - vcqf_pkg::SubMin);
        end else begin
            sub_idx = in_count[vcqf_pkg::SubIdxW-1:0]
                    - vcqf_pkg::SubIdxW'(vcqf_pkg::SubMin);
        end
        if (in_count > vcqf_pkg::CountW'(vcqf_pkg::IndelMax)) begin
            indel_idx = vcqf_pkg::IndelIdxW'(vcqf_pkg::IndelMax - vcqf_pkg::IndelMin);
        end else begin
            indel_idx = in_count[vcqf_pkg::IndelIdxW-1:0]
                      - vcqf_pkg::IndelIdxW'(vcqf_pkg::IndelMin);
        end
    end

    assign sub_row   = vcqf_pkg::sub_thr(cfg.read_set, sub_idx);
    assign indel_row = vcqf_pkg::indel_thr(cfg.read_set, indel_idx);
    assign row       = is_sub ? sub_row : indel_row;

    assign num_next = vcqf_pkg::PctW'(in_count) * vcqf_pkg::PctW'(vcqf_pkg::PctFull);

    always_comb begin
        side_next.homo_del = is_del & run_one;
        side_next.bypass   = cfg.bypass;
        side_next.cnt_ok   = is_sub ? sub_ok : indel_ok;
        side_next.cov_zero = (in_cov == '0);
        side_next.thr_pct  = row.pct;
        side_next.thr_scr  = row.scr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cnt_reg  <= in_count;
            sum_reg  <= in_score;
            cov_reg  <= in_cov;
            num_reg  <= num_next;
            side_reg <= side_next;
        end
    end

    assign out_valid   = vld_reg;
    assign out_count   = cnt_reg;
    assign out_score   = sum_reg;
    assign out_cov     = cov_reg;
    assign out_pct_num = num_reg;
    assign out_side    = side_reg;

endmodule

// File: design/vcqf_decide.sv
// output stage: percentage fix for zero coverage, threshold compares, keep decision
module vcqf_decide (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [vcqf_pkg::ScoreW-1:0]   in_mean,
    input  logic [vcqf_pkg::PctW-1:0]     in_pct,
    input  vcqf_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic                          out_keep,
    output logic [vcqf_pkg::ScoreW-1:0]   out_mean,
    output logic [vcqf_pkg::PctW-1:0]     out_pct
);

    logic                        vld_reg;
    logic                        keep_reg;
    logic [vcqf_pkg::ScoreW-1:0] mean_reg;
    logic [vcqf_pkg::PctW-1:0]   pct_reg;

    logic                        keep_next;
    logic [vcqf_pkg::PctW-1:0]   pct_next;
    logic                        pass;

    assign pct_next = in_side.cov_zero ? vcqf_pkg::PctW'(vcqf_pkg::PctFull) : in_pct;

    assign pass = (in_mean <= vcqf_pkg::ScoreW'(in_side.thr_scr))
                & (pct_next >= vcqf_pkg::PctW'(in_side.thr_pct));

    always_comb begin
        priority if (in_side.homo_del && pct_next <= vcqf_pkg::PctW'(vcqf_pkg::HomoPct)) begin
            keep_next = 1'b0;
        end else if (in_side.bypass) begin
            keep_next = 1'b1;
        end else if (!in_side.cnt_ok) begin
            keep_next = 1'b0;
        end else begin
            keep_next = pass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            keep_reg <= keep_next;
            mean_reg <= in_mean;
            pct_reg  <= pct_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_keep  = keep_reg;
    assign out_mean  = mean_reg;
    assign out_pct   = pct_reg;

endmodule

// File: design/variant_call_quality_filter_unit.sv
// top level of the variant call quality filter with its configuration port
// One variant beat enters per clock while the result side is not stalled. Each beat passes one
// input stage (class, homopolymer check, table lookup, count times 100), then the two pipelined
// restoring dividers for the mean score and the support percentage, which run side by side
// with two quotient bits per stage by default, and then one decision stage. When the result
// side stalls the whole pipeline holds; bubbles stay in place. Configuration registers:
// bypass_filter at address 0, read_length_set at address 4.
module variant_call_quality_filter_unit #(
    parameter int DivStepBits = vcqf_pkg::DivStepBits
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [vcqf_pkg::CountW-1:0]   s_support_count,
    input  logic [vcqf_pkg::ScoreW-1:0]   s_score_sum,
    input  logic [vcqf_pkg::CovW-1:0]     s_coverage,
    input  logic [vcqf_pkg::LenW-1:0]     s_ref_length,
    input  logic [vcqf_pkg::LenW-1:0]     s_alt_length,
    input  logic [vcqf_pkg::BasesW-1:0]   s_preceding_bases,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_keep,
    output logic [vcqf_pkg::ScoreW-1:0]   m_mean_score,
    output logic [vcqf_pkg::PctW-1:0]     m_support_percent
);

    logic bypass_reg;
    logic read_set_reg;
    logic cfg_wr;
    vcqf_pkg::cfg_t cfg;

    logic en;

    logic                        fr_valid;
    logic [vcqf_pkg::CountW-1:0] fr_count;
    logic [vcqf_pkg::ScoreW-1:0] fr_score;
    logic [vcqf_pkg::CovW-1:0]   fr_cov;
    logic [vcqf_pkg::PctW-1:0]   fr_pct_num;
    vcqf_pkg::side_t             fr_side;

    logic                         md_valid;
    logic [vcqf_pkg::DivW-1:0]    md_quo;
    logic [vcqf_pkg::SideW-1:0]   md_side;
    logic                         pd_valid;
    logic [vcqf_pkg::DivW-1:0]    pd_quo;
    logic                         pd_side;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg   <= 1'b0;
            read_set_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                vcqf_pkg::RegBypass:  bypass_reg   <= pwdata[0];
                vcqf_pkg::RegReadLen: read_set_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vcqf_pkg::RegBypass:  prdata = {31'd0, bypass_reg};
            vcqf_pkg::RegReadLen: prdata = {31'd0, read_set_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.bypass   = bypass_reg;
    assign cfg.read_set = read_set_reg;

    // whole pipeline advances unless the result beat is stalled
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    vcqf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .in_count    (s_support_count),
        .in_score    (s_score_sum),
        .in_cov      (s_coverage),
        .in_ref_len  (s_ref_length),
        .in_alt_len  (s_alt_length),
        .in_bases    (s_preceding_bases),
        .out_valid   (fr_valid),
        .out_count   (fr_count),
        .out_score   (fr_score),
        .out_cov     (fr_cov),
        .out_pct_num (fr_pct_num),
        .out_side    (fr_side)
    );

    vcqf_div_pipe #(
        .W        (vcqf_pkg::DivW),
        .DW       (vcqf_pkg::CountW),
        .StepBits (DivStepBits),
        .SideW    (vcqf_pkg::SideW)
    ) u_mean_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (fr_valid),
        .in_dividend  (fr_score),
        .in_divisor   (fr_count),
        .in_side      (fr_side),
        .out_valid    (md_valid),
        .out_quotient (md_quo),
        .out_side     (md_side)
    );

    vcqf_div_pipe #(
        .W        (vcqf_pkg::DivW),
        .DW       (vcqf_pkg::CovW),
        .StepBits (DivStepBits),
        .SideW    (1)
    ) u_pct_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (fr_valid),
        .in_dividend  (vcqf_pkg::DivW'(fr_pct_num)),
        .in_divisor   (fr_cov),
        .in_side      (fr_side.cov_zero),
        .out_valid    (pd_valid),
        .out_quotient (pd_quo),
        .out_side     (pd_side)
    );

    vcqf_pkg::side_t dec_side;

    always_comb begin
        dec_side          = vcqf_pkg::side_t'(md_side);
        dec_side.cov_zero = pd_side;
    end

    vcqf_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (md_valid & pd_valid),
        .in_mean   (md_quo),
        .in_pct    (pd_quo[vcqf_pkg::PctW-1:0]),
        .in_side   (dec_side),
        .out_valid (m_valid),
        .out_keep  (m_keep),
        .out_mean  (m_mean_score),
        .out_pct   (m_support_percent)
    );

endmodule

// File: test/variant_call_quality_filter_unit_test.sv
// testbench of the variant call quality filter: results checked against a local predictor
typedef struct {
    logic [vcqf_pkg::CountW-1:0] support_count;
    logic [vcqf_pkg::ScoreW-1:0] score_sum;
    logic [vcqf_pkg::CovW-1:0]   coverage;
    logic [vcqf_pkg::LenW-1:0]   ref_length;
    logic [vcqf_pkg::LenW-1:0]   alt_length;
    logic [vcqf_pkg::BasesW-1:0] preceding_bases;
} candidate_t;

typedef struct {
    logic                        keep;
    logic [vcqf_pkg::ScoreW-1:0] mean_score;
    logic [vcqf_pkg::PctW-1:0]   support_percent;
} verdict_t;

class keep_verdict_board;
    // threshold rows, index 0 and index 1 are the two read length sets
    int unsigned sub_pct [2][18] = '{
        '{15, 17, 18, 20, 21, 22, 22, 24, 24, 28, 29, 29, 32, 32, 35, 35, 35, 40},
        '{15, 17, 18, 20, 21, 22, 24, 25, 27, 27, 29, 30, 31, 34, 34, 34, 35, 40}};
    int unsigned sub_scr [2][18] = '{
        '{16, 17, 18, 18, 20, 21, 21, 21, 21, 21, 22, 23, 24, 25, 25, 25, 25, 25},
        '{16, 20, 20, 21, 21, 21, 22, 23, 23, 25, 25, 27, 27, 27, 27, 29, 29, 29}};
    int unsigned indel_pct [2][10] = '{
        '{10, 12, 13, 14, 14, 1, 1, 1, 1, 1},
        '{9, 12, 12, 13, 15, 17, 18, 2, 1, 1}};
    int unsigned indel_scr [2][10] = '{
        '{16, 21, 21, 22, 22, 23, 25, 25, 30, 40},
        '{21, 22, 22, 24, 25, 25, 25, 26, 27, 40}};

    logic     bypass = 1'b0;
    logic     read_set = 1'b0;
    int       mismatch_count = 0;
    verdict_t pending_verdicts [$];

    function void set_register(logic [vcqf_pkg::RegIdxW-1:0] idx, logic [31:0] value);
        case (idx)
            vcqf_pkg::RegBypass:  bypass = value[0];
            vcqf_pkg::RegReadLen: read_set = value[0];
            default: ;
        endcase
    endfunction

    function verdict_t judge_variant(candidate_t v);
        verdict_t    r;
        logic [31:0] scaled;
        logic [31:0] pct;
        logic        homopolymer;
        int unsigned row;
        int unsigned set_idx;
        r.mean_score = (v.support_count != 0) ? v.score_sum / v.support_count : '1;
        scaled = 32'(v.support_count) * 32'(vcqf_pkg::PctFull);
        pct = (v.coverage != 0) ? scaled / v.coverage : 32'(vcqf_pkg::PctFull);
        r.support_percent = pct[vcqf_pkg::PctW-1:0];
        homopolymer = 1'b1;
        for (int i = 1; i < vcqf_pkg::NumBases; i++) begin
            if (v.preceding_bases[4*i +: 4] != v.preceding_bases[3:0]) begin
                homopolymer = 1'b0;
            end
        end
        set_idx = read_set;
        if (v.ref_length > v.alt_length && pct <= vcqf_pkg::HomoPct && homopolymer) begin
            r.keep = 1'b0;
        end else if (bypass) begin
            r.keep = 1'b1;
        end else if (v.ref_length == v.alt_length) begin
            if (v.support_count < vcqf_pkg::SubMin) begin
                r.keep = 1'b0;
            end else begin
                row = (v.support_count > vcqf_pkg::SubMax) ? vcqf_pkg::SubMax : v.support_count;
                row = row - vcqf_pkg::SubMin;
                r.keep = r.mean_score <= sub_scr[set_idx][row] && pct >= sub_pct[set_idx][row];
            end
        end else begin
            if (v.support_count < vcqf_pkg::IndelMin) begin
                r.keep = 1'b0;
            end else begin
                row = (v.support_count > vcqf_pkg::IndelMax) ? vcqf_pkg::IndelMax
                                                              : v.support_count;
                row = row - vcqf_pkg::IndelMin;
                r.keep = r.mean_score <= indel_scr[set_idx][row]
                         && pct >= indel_pct[set_idx][row];
            end
        end
        return r;
    endfunction

    function void note_variant(candidate_t v);
        pending_verdicts.push_back(judge_variant(v));
    endfunction

    function void check_verdict(verdict_t got);
        verdict_t want;
        if (pending_verdicts.size() == 0) begin
            $display("%0t unexpected result beat: keep %0d mean %0d percent %0d",
                     $time, got.keep, got.mean_score, got.support_percent);
            mismatch_count++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.keep !== want.keep) begin
            $display("%0t keep: expected %0d, actual %0d", $time, want.keep, got.keep);
            mismatch_count++;
        end
        if (got.mean_score !== want.mean_score) begin
            $display("%0t mean_score: expected %0d, actual %0d",
                     $time, want.mean_score, got.mean_score);
            mismatch_count++;
        end
        if (got.support_percent !== want.support_percent) begin
            $display("%0t support_percent: expected %0d, actual %0d",
                     $time, want.support_percent, got.support_percent);
            mismatch_count++;
        end
    endfunction
endclass

module variant_call_quality_filter_unit_test;

    localparam int StallLimit = 1000;
    localparam int PhaseItems = 260;

    typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxHold} rx_mode_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [vcqf_pkg::CountW-1:0]   s_support_count = '0;
    logic [vcqf_pkg::ScoreW-1:0]   s_score_sum = '0;
    logic [vcqf_pkg::CovW-1:0]     s_coverage = '0;
    logic [vcqf_pkg::LenW-1:0]     s_ref_length = '0;
    logic [vcqf_pkg::LenW-1:0]     s_alt_length = '0;
    logic [vcqf_pkg::BasesW-1:0]   s_preceding_bases = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_keep;
    logic [vcqf_pkg::ScoreW-1:0]   m_mean_score;
    logic [vcqf_pkg::PctW-1:0]     m_support_percent;

    keep_verdict_board board = new();
    int       idle_cycles = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RxOpen;
    int       rx_left = 0;

    variant_call_quality_filter_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_support_count   (s_support_count),
        .s_score_sum       (s_score_sum),
        .s_coverage        (s_coverage),
        .s_ref_length      (s_ref_length),
        .s_alt_length      (s_alt_length),
        .s_preceding_bases (s_preceding_bases),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_keep            (m_keep),
        .m_mean_score      (m_mean_score),
        .m_support_percent (m_support_percent)
    );

    always #10 aclk = ~aclk;

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RxHold) ? $urandom_range(1, 24) : $urandom_range(5, 60);
        end
        rx_left--;
        case (rx_mode)
            RxOpen:   m_ready <= 1'b1;
            RxCoin:   m_ready <= 1'($urandom_range(0, 1));
            RxSparse: m_ready <= ($urandom_range(0, 3) == 0);
            default:  m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin : beat_monitor
        candidate_t seen;
        verdict_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.support_count = s_support_count;
                seen.score_sum = s_score_sum;
                seen.coverage = s_coverage;
                seen.ref_length = s_ref_length;
                seen.alt_length = s_alt_length;
                seen.preceding_bases = s_preceding_bases;
                board.note_variant(seen);
            end
            if (m_valid && m_ready) begin
                got.keep = m_keep;
                got.mean_score = m_mean_score;
                got.support_percent = m_support_percent;
                board.check_verdict(got);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= StallLimit) begin
                $display("timeout: no beat accepted for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_register(input logic [vcqf_pkg::RegIdxW-1:0] idx, input logic bit_value);
        logic [31:0] data;
        data = $urandom();
        data[0] = bit_value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_register(idx, data);
        @(posedge aclk);
    endtask

    task automatic offer_variant(input candidate_t v);
        s_valid <= 1'b1;
        s_support_count <= v.support_count;
        s_score_sum <= v.score_sum;
        s_coverage <= v.coverage;
        s_ref_length <= v.ref_length;
        s_alt_length <= v.alt_length;
        s_preceding_bases <= v.preceding_bases;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results(input int tail);
        s_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    function automatic candidate_t pack_variant(input logic [15:0] cnt, input logic [31:0] sum,
                                                input logic [31:0] cov, input logic [7:0] rlen,
                                                input logic [7:0] alen, input logic [47:0] bases);
        candidate_t v;
        v.support_count = cnt;
        v.score_sum = sum;
        v.coverage = cov;
        v.ref_length = rlen;
        v.alt_length = alen;
        v.preceding_bases = bases;
        return v;
    endfunction

    // small counts, scores and percentages close to the threshold rows
    function automatic candidate_t shaped_variant();
        candidate_t  v;
        int unsigned cnt;
        int unsigned mean;
        int unsigned pct;
        logic [3:0]  nib;
        cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 400);
        mean = $urandom_range(10, 45);
        pct = $urandom_range(0, 60);
        v.support_count = 16'(cnt);
        v.score_sum = cnt * mean + $urandom_range(0, (cnt > 0) ? cnt - 1 : 0);
        if (pct == 0) begin
            v.coverage = $urandom_range(0, 1) ? 32'd0 : 32'(cnt * 200 + 7);
        end else begin
            v.coverage = cnt * 100 / pct + $urandom_range(0, 1);
        end
        case ($urandom_range(0, 2))
            0: begin
                v.ref_length = 8'($urandom_range(0, 4));
                v.alt_length = v.ref_length;
            end
            1: begin
                v.ref_length = 8'($urandom_range(1, 3));
                v.alt_length = v.ref_length + 8'($urandom_range(1, 6));
            end
            default: begin
                v.alt_length = 8'($urandom_range(0, 3));
                v.ref_length = v.alt_length + 8'($urandom_range(1, 6));
            end
        endcase
        nib = 4'($urandom());
        case ($urandom_range(0, 2))
            0: v.preceding_bases = {12{nib}};
            1: v.preceding_bases = {12{nib}} ^ (48'd1 << $urandom_range(0, 47));
            default: v.preceding_bases = {16'($urandom()), 32'($urandom())};
        endcase
        return v;
    endfunction

    function automatic candidate_t noise_variant();
        candidate_t v;
        v.support_count = 16'($urandom());
        v.score_sum = $urandom();
        v.coverage = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000);
        v.ref_length = 8'($urandom());
        v.alt_length = 8'($urandom());
        v.preceding_bases = {16'($urandom()), 32'($urandom())};
        return v;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 12));
                end
            end
            burst_left--;
            offer_variant(($urandom_range(0, 4) == 0) ? noise_variant() : shaped_variant());
        end
    endtask

    initial begin
        logic [47:0] homo3;
        int          phase;
        homo3 = {12{4'h3}};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_variant(pack_variant(16'd0, 32'd0, 32'd0, 8'd0, 8'd0, 48'd0));
        offer_variant(pack_variant('1, '1, '1, 8'hFF, 8'hFF, '1));
        offer_variant(pack_variant('1, 32'd1234567, 32'd1, 8'd1, 8'd1, 48'h0123456789AB));
        offer_variant(pack_variant(16'd5, 32'd50, 32'd20, 8'd3, 8'd1, homo3));
        offer_variant(pack_variant(16'd5, 32'd50, 32'd19, 8'd3, 8'd1, homo3));
        offer_variant(pack_variant(16'd5, 32'd50, 32'd40, 8'd2, 8'd1, {4'h1, {11{4'h2}}}));
        offer_variant(pack_variant(16'd1, 32'd10, 32'd2, 8'd1, 8'd4, 48'hFEDCBA987654));
        offer_variant(pack_variant(16'd2, 32'd32, 32'd20, 8'd1, 8'd2, 48'd0));
        offer_variant(pack_variant(16'd2, 32'd34, 32'd20, 8'd1, 8'd2, 48'd0));
        offer_variant(pack_variant(16'd2, 32'd10, 32'd5, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd3, 32'd48, 32'd20, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd3, 32'd51, 32'd20, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd20, 32'd500, 32'd50, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd21, 32'd525, 32'd52, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd1000, 32'd25000, 32'd2500, 8'd1, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd11, 32'd440, 32'd1100, 8'd4, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd12, 32'd480, 32'd1200, 8'd4, 8'd1, 48'd0));
        offer_variant(pack_variant(16'd0, 32'd77, 32'd0, 8'd5, 8'd2, homo3));
        offer_variant(pack_variant(16'd0, 32'd77, 32'd5, 8'd5, 8'd2, homo3));
        offer_variant(pack_variant(16'd4, 32'd40, 32'd10, 8'd1, 8'd0, {12{4'hF}}));
        offer_variant(pack_variant(16'd4, 32'd40, 32'd16, 8'd0, 8'd255, 48'd0));
        offer_variant(pack_variant(16'd6, 32'd0, '1, 8'd2, 8'd2, {12{4'h0}}));

        for (phase = 1; phase <= 5; phase++) begin
            drain_results(25);
            write_register(vcqf_pkg::RegBypass, phase[0]);
            write_register(vcqf_pkg::RegReadLen, phase[1]);
            run_random(PhaseItems);
        end

        drain_results(40);
        if (board.mismatch_count == 0 && board.pending_verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
